>>> hdl/bitmap_thread_scheduler_macros.svh
// Assertion macros for the thread scheduler.
`ifndef BITMAP_THREAD_SCHEDULER_MACROS_SVH
`define BITMAP_THREAD_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define BTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define BTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/bts_pkg.sv
package bts_pkg;
	localparam int unsigned THREADS_DEF = 32;
	localparam int unsigned WAIT_QUEUES_DEF = 8;
	localparam logic [9:0] MS_PER_TICK_RST = 10'd100;

	typedef enum logic [3:0] {
		OP_TICK = 4'd0, OP_CREATE = 4'd1, OP_YIELD = 4'd2, OP_SLEEP = 4'd3,
		OP_EXIT = 4'd4, OP_JOIN = 4'd5, OP_CANCEL = 4'd6, OP_WAIT = 4'd7,
		OP_SIGNAL = 4'd8
	} op_t;

	typedef struct packed {
		logic [3:0]  operation;
		logic [4:0]  target_thread;
		logic [7:0]  thread_priority;
		logic [15:0] sleep_ms;
		logic [2:0]  queue_id;
		logic signed [31:0] exit_code;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  running_thread;
		logic        status;
		logic [4:0]  created_thread;
		logic [31:0] woken_mask;
		logic signed [31:0] delivered_code;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch input word, begin op
		logic div_step;  // one quotient bit
		logic walk;      // process one thread entry
		logic finish;    // apply final bitmap updates and dispatch
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic walk_done;
		logic need_div;
		logic need_walk;
	} stat_t;
endpackage

>>> hdl/bts_ctrl.sv
module bts_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  bts_pkg::stat_t st,
	output bts_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);
	import bts_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_DECODE = 5'b00010, S_DIV = 5'b00100,
		S_WALK = 5'b01000, S_FIN = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start && !done) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.need_div) state_d = S_DIV;
				else if (st.need_walk) state_d = S_WALK;
				else state_d = S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) state_d = S_FIN;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (st.walk_done) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE) || done;
endmodule

>>> hdl/bts_datapath.sv
module bts_datapath #(
	parameter int unsigned THREADS = bts_pkg::THREADS_DEF,
	parameter int unsigned WAIT_QUEUES = bts_pkg::WAIT_QUEUES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  bts_pkg::in_word_t in_word,
	input  bts_pkg::cmd_t cmd,
	input  logic cfg_we,
	input  logic [9:0] cfg_data,
	output bts_pkg::stat_t st,
	output bts_pkg::out_word_t result_q
);
	import bts_pkg::*;

	localparam int unsigned TW = $clog2(THREADS + 1);
	localparam int unsigned TI = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int unsigned QI = (WAIT_QUEUES > 1) ? $clog2(WAIT_QUEUES) : 1;
	localparam logic [TW-1:0] IDLE_IDX = TW'(THREADS);

	logic [9:0] ms_per_tick_q;
	logic [THREADS-1:0] ready_q, sleep_q, alloc_q, woken_q;
	logic [THREADS-1:0] join_q [THREADS];
	logic [THREADS-1:0] wait_q [WAIT_QUEUES];
	logic [15:0] ticks_q [THREADS];
	logic [7:0] prio_q [THREADS];
	logic [7:0] plimit_q;
	logic [TW-1:0] run_q;

	in_word_t in_q;
	logic [TI-1:0] idx_q;
	logic [TI:0] walk_cnt_q;
	logic walk_stop_q;
	logic [TI-1:0] term_q;
	logic status_q;
	logic [4:0] created_q;
	logic [31:0] woken_out_q;
	logic signed [31:0] code_q;
	// divider
	logic [16:0] dividend_q, quot_q;
	logic [10:0] rem_q;
	logic [4:0] div_cnt_q;

	op_t op;
	logic idle;
	logic [TI-1:0] run_i;
	logic tgt_ok, q_ok, do_term;
	logic [TI-1:0] tgt_i;
	logic [QI-1:0] q_i;
	logic [9:0] divisor;
	logic [10:0] rem_sh;

	assign op = op_t'(in_q.operation);
	assign idle = (run_q >= IDLE_IDX);
	assign run_i = run_q[TI-1:0];
	assign tgt_i = TI'(in_q.target_thread);
	assign tgt_ok = ({27'd0, in_q.target_thread} < 32'(THREADS)) && alloc_q[tgt_i];
	assign q_i = QI'(in_q.queue_id);
	assign q_ok = {29'd0, in_q.queue_id} < 32'(WAIT_QUEUES);
	assign do_term = (op == OP_EXIT && !idle) || (op == OP_CANCEL && tgt_ok);
	assign divisor = (ms_per_tick_q == 10'd0) ? 10'd1 : ms_per_tick_q;
	assign rem_sh = {rem_q[9:0], dividend_q[16]};

	assign st.need_div = (op == OP_SLEEP) && !idle;
	assign st.need_walk = (op == OP_TICK) || do_term;
	assign st.div_done = (div_cnt_q == 5'd16);
	assign st.walk_done = walk_stop_q || (walk_cnt_q == (TI+1)'(THREADS - 1));

	function automatic logic [TW-1:0] lowest(input logic [THREADS-1:0] m);
		logic [TW-1:0] r;
		r = IDLE_IDX;
		for (int i = THREADS - 1; i >= 0; i--) if (m[i]) r = TW'(i);
		return r;
	endfunction

	function automatic logic [TW-1:0] highest(input logic [THREADS-1:0] m);
		logic [TW-1:0] r;
		r = IDLE_IDX;
		for (int i = 0; i < THREADS; i++) if (m[i]) r = TW'(i);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_per_tick_q <= MS_PER_TICK_RST;
			ready_q <= '0;
			sleep_q <= '0;
			alloc_q <= THREADS'(1);
			for (int i = 0; i < THREADS; i++) begin
				join_q[i] <= '0;
				ticks_q[i] <= '0;
				prio_q[i] <= (i == 0) ? 8'd1 : 8'd0;
			end
			for (int i = 0; i < WAIT_QUEUES; i++) wait_q[i] <= '0;
			plimit_q <= 8'd1;
			run_q <= '0;
		end else begin
			if (cfg_we) ms_per_tick_q <= cfg_data;
			if (cmd.walk) begin
				if (op == OP_TICK) begin
					if (sleep_q[idx_q] && !walk_stop_q) begin
						if (ticks_q[idx_q] <= 16'd1) begin
							ticks_q[idx_q] <= '0;
							sleep_q[idx_q] <= 1'b0;
							ready_q[idx_q] <= 1'b1;
						end else begin
							ticks_q[idx_q] <= ticks_q[idx_q] - 16'd1;
						end
					end
				end else begin
					join_q[idx_q][term_q] <= 1'b0;
					if (alloc_q[idx_q] && idx_q != term_q) begin
						if (plimit_q < prio_q[idx_q]) plimit_q <= prio_q[idx_q];
						if (join_q[term_q][idx_q]) ready_q[idx_q] <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				logic [THREADS-1:0] rdy;
				logic [TW-1:0] d, c;
				logic [7:0] pl;
				rdy = ready_q;
				d = run_q;
				unique case (op)
					OP_TICK, OP_YIELD: begin
						if (!idle) rdy[run_i] = 1'b1;
						d = lowest(rdy);
					end
					OP_CREATE: begin
						c = (in_q.thread_priority == 8'd0) ? lowest(~alloc_q)
							: highest(~alloc_q);
						if (c != IDLE_IDX) begin
							pl = (plimit_q < in_q.thread_priority) ? in_q.thread_priority
								: plimit_q;
							alloc_q[c[TI-1:0]] <= 1'b1;
							rdy[c[TI-1:0]] = 1'b1;
							prio_q[c[TI-1:0]] <= in_q.thread_priority;
							plimit_q <= pl;
							ticks_q[c[TI-1:0]] <= {9'd0, pl[7:1]};
						end
					end
					OP_SLEEP: begin
						if (!idle) begin
							ticks_q[run_i] <= (quot_q[16]) ? 16'hffff : quot_q[15:0];
							sleep_q[run_i] <= 1'b1;
						end
						d = lowest(rdy);
					end
					OP_EXIT, OP_CANCEL, OP_JOIN, OP_WAIT: begin
						if (do_term) begin
							alloc_q[term_q] <= 1'b0;
							rdy[term_q] = 1'b0;
							sleep_q[term_q] <= 1'b0;
							join_q[term_q] <= '0;
							for (int i = 0; i < WAIT_QUEUES; i++) wait_q[i][term_q] <= 1'b0;
						end
						if (op == OP_EXIT || (op == OP_CANCEL && tgt_ok && run_q == TW'(tgt_i)))
							d = lowest(rdy);
						if (op == OP_JOIN) begin
							if (idle) d = lowest(rdy);
							else if (tgt_ok) begin
								join_q[tgt_i][run_i] <= 1'b1;
								d = lowest(rdy);
							end
						end
						if (op == OP_WAIT && q_ok) begin
							if (!idle) wait_q[q_i][run_i] <= 1'b1;
							d = lowest(rdy);
						end
					end
					OP_SIGNAL: begin
						if (q_ok) begin
							c = lowest(wait_q[q_i]);
							if (c != IDLE_IDX) begin
								wait_q[q_i][c[TI-1:0]] <= 1'b0;
								rdy[c[TI-1:0]] = 1'b1;
							end
						end
					end
					default: ;
				endcase
				if (d != IDLE_IDX) rdy[d[TI-1:0]] = 1'b0;
				ready_q <= rdy;
				run_q <= d;
			end
		end
	end

	// per-item scratch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q <= '0;
			idx_q <= '0;
			walk_cnt_q <= '0;
			walk_stop_q <= 1'b0;
			div_cnt_q <= '0;
			woken_q <= '0;
			dividend_q <= '0;
			rem_q <= '0;
			quot_q <= '0;
			term_q <= '0;
		end else begin
			if (cmd.load) begin
				in_q <= in_word;
				idx_q <= '0;
				walk_cnt_q <= '0;
				walk_stop_q <= 1'b0;
				div_cnt_q <= '0;
				woken_q <= '0;
				dividend_q <= {1'b0, in_word.sleep_ms} + 17'd1;
				rem_q <= '0;
				quot_q <= '0;
				term_q <= (op_t'(in_word.operation) == OP_EXIT) ? run_q[TI-1:0]
					: TI'(in_word.target_thread);
			end
			if (cmd.div_step) begin
				dividend_q <= {dividend_q[15:0], 1'b0};
				if (rem_sh >= {1'b0, divisor}) begin
					rem_q <= rem_sh - {1'b0, divisor};
					quot_q <= {quot_q[15:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quot_q <= {quot_q[15:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			if (cmd.walk) begin
				idx_q <= idx_q + TI'(1);
				walk_cnt_q <= walk_cnt_q + (TI+1)'(1);
				if (op == OP_TICK) begin
					if (sleep_q[idx_q] && !walk_stop_q && ticks_q[idx_q] <= 16'd1) begin
						walk_stop_q <= 1'b1;
						woken_q[idx_q] <= 1'b1;
					end
				end else if (alloc_q[idx_q] && idx_q != term_q && join_q[term_q][idx_q]) begin
					woken_q[idx_q] <= 1'b1;
				end
			end
		end
	end

	// 17 divide steps, one per dividend bit, counts 0 through 16

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 1'b0;
			created_q <= '0;
			woken_out_q <= '0;
			code_q <= '0;
		end else if (cmd.finish) begin
			logic [TW-1:0] c, h;
			logic stat_v;
			logic [4:0] cr;
			logic [31:0] wk;
			c = (in_q.thread_priority == 8'd0) ? lowest(~alloc_q) : highest(~alloc_q);
			h = lowest(wait_q[q_i]);
			stat_v = 1'b0;
			cr = '0;
			wk = 32'(woken_q);
			if (op == OP_CREATE) begin
				if (c == IDLE_IDX) stat_v = 1'b1;
				else begin
					cr = 5'(c);
					wk = 32'(THREADS'(1) << c[TI-1:0]);
				end
			end
			if ((op == OP_JOIN && !idle && !tgt_ok) || (op == OP_CANCEL && !tgt_ok))
				stat_v = 1'b1;
			if (op == OP_SIGNAL && q_ok && h != IDLE_IDX)
				wk = 32'(THREADS'(1) << h[TI-1:0]);
			status_q <= stat_v;
			created_q <= cr;
			woken_out_q <= wk;
			code_q <= do_term ? in_q.exit_code : 32'sd0;
		end
	end

	always_comb begin
		result_q.running_thread = 6'(run_q);
		result_q.status = status_q;
		result_q.created_thread = created_q;
		result_q.woken_mask = woken_out_q;
		result_q.delivered_code = code_q;
	end
endmodule

>>> hdl/bitmap_thread_scheduler.sv
// Thread scheduler on bitmaps. Pulse start while busy is low to issue one
// operation; the result appears for a single cycle with done high and cannot
// be stalled, so sample it when done is seen. Sleep runs the serial divider
// (one quotient bit per cycle), and tick, exit and cancel walk the thread table
// (one thread entry per cycle; a tick walk stops at the first one it wakes).
// Write ms_per_tick via cfg_valid/cfg_ready only while idle; it is not enforced.
module bitmap_thread_scheduler #(
	parameter int unsigned THREADS = bts_pkg::THREADS_DEF,
	parameter int unsigned WAIT_QUEUES = bts_pkg::WAIT_QUEUES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  bts_pkg::in_word_t cmd_word,
	output logic done,
	output bts_pkg::out_word_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [9:0] cfg_data
);
	import bts_pkg::*;
	`include "bitmap_thread_scheduler_macros.svh"

	cmd_t cmd;
	stat_t st;
	out_word_t res_w;

	bts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .st(st),
		.cmd(cmd), .busy(busy), .done(done)
	);

	bts_datapath #(.THREADS(THREADS), .WAIT_QUEUES(WAIT_QUEUES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(cmd_word), .cmd(cmd),
		.cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.st(st), .result_q(res_w)
	);

	assign cfg_ready = 1'b1;
	assign result = res_w;

	`BTS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`BTS_ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	`BTS_ASSERT_IMPL(a_run_range, clk, arst_n, done, result.running_thread <= 6'(THREADS))
endmodule

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bts_pkg::*;

	localparam int NTHR = 32;
	localparam int NQ = 8;
	localparam logic [3:0] OP_UNUSED = 4'd15;

	typedef struct {
		bit is_cfg;
		in_word_t word;
		logic [9:0] cfg;
	} sched_req_t;

	logic clk, arst_n;
	logic start, busy, done;
	in_word_t cmd_word;
	out_word_t result;
	logic cfg_valid, cfg_ready;
	logic [9:0] cfg_data;

	bitmap_thread_scheduler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_word(cmd_word),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	sched_req_t pending_reqs[$];
	out_word_t expected_words[$];
	int errors = 0;
	int gap_left = 0;
	int idle_cycles = 0;
	bit no_gaps = 0;

	// shadow scheduler state
	logic [31:0] rdy_m, slp_m, alc_m;
	logic [31:0] join_m[NTHR];
	logic [31:0] wait_m[NQ];
	logic [15:0] ticks[NTHR];
	logic [7:0] prios[NTHR];
	logic [7:0] prio_lim;
	int unsigned run_idx;
	logic [9:0] tick_div;

	function automatic int unsigned lowest_set(logic [31:0] m);
		int unsigned i;
		for (i = 0; i < NTHR; i++)
			if (m[i])
				return i;
		return NTHR;
	endfunction

	function automatic void pick_next();
		int unsigned i;
		i = lowest_set(rdy_m);
		if (i < NTHR)
			rdy_m[i] = 1'b0;
		run_idx = i;
	endfunction

	function automatic logic [31:0] retire_thread(int unsigned t);
		logic [31:0] woken;
		int unsigned j;
		woken = '0;
		alc_m[t] = 1'b0;
		rdy_m[t] = 1'b0;
		slp_m[t] = 1'b0;
		for (j = 0; j < NQ; j++)
			wait_m[j][t] = 1'b0;
		for (j = 0; j < NTHR; j++)
			join_m[j][t] = 1'b0;
		for (j = 0; j < NTHR; j++) begin
			if (alc_m[j]) begin
				if (prio_lim < prios[j])
					prio_lim = prios[j];
				if (join_m[t][j]) begin
					rdy_m[j] = 1'b1;
					woken[j] = 1'b1;
				end
			end
		end
		join_m[t] = '0;
		return woken;
	endfunction

	function automatic void sched_reset();
		int j;
		rdy_m = '0;
		slp_m = '0;
		alc_m = 32'd1;
		for (j = 0; j < NTHR; j++) begin
			join_m[j] = '0;
			ticks[j] = '0;
			prios[j] = '0;
		end
		for (j = 0; j < NQ; j++)
			wait_m[j] = '0;
		prios[0] = 8'd1;
		prio_lim = 8'd1;
		run_idx = 0;
		tick_div = MS_PER_TICK_RST;
	endfunction

	function automatic out_word_t schedule_op(in_word_t w);
		out_word_t o;
		int unsigned r, j, idx, dv, t, h;
		bit idle, found;
		logic [31:0] free_bits;
		o = '0;
		r = run_idx;
		idle = (r >= NTHR);
		case (w.operation)
			OP_TICK: begin
				found = 0;
				for (j = 0; j < NTHR; j++) begin
					if (!found && slp_m[j]) begin
						if (ticks[j] <= 1) begin
							ticks[j] = '0;
							slp_m[j] = 1'b0;
							rdy_m[j] = 1'b1;
							o.woken_mask = 32'd1 << j;
							found = 1;
						end else begin
							ticks[j] = ticks[j] - 16'd1;
						end
					end
				end
				if (!idle)
					rdy_m[r] = 1'b1;
				pick_next();
			end
			OP_CREATE: begin
				free_bits = ~alc_m;
				idx = NTHR;
				if (w.thread_priority == 0) begin
					idx = lowest_set(free_bits);
				end else begin
					for (j = NTHR; j > 0; j--)
						if (idx == NTHR && free_bits[j-1])
							idx = j - 1;
				end
				if (idx >= NTHR) begin
					o.status = 1'b1;
				end else begin
					alc_m[idx] = 1'b1;
					rdy_m[idx] = 1'b1;
					prios[idx] = w.thread_priority;
					if (prio_lim < w.thread_priority)
						prio_lim = w.thread_priority;
					ticks[idx] = {8'd0, prio_lim >> 1};
					o.created_thread = idx[4:0];
					o.woken_mask = 32'd1 << idx;
				end
			end
			OP_YIELD: begin
				if (!idle)
					rdy_m[r] = 1'b1;
				pick_next();
			end
			OP_SLEEP: begin
				if (!idle) begin
					dv = (tick_div == 0) ? 1 : tick_div;
					t = (w.sleep_ms + 1) / dv;
					ticks[r] = (t > 65535) ? 16'hffff : t[15:0];
					slp_m[r] = 1'b1;
				end
				pick_next();
			end
			OP_EXIT: begin
				if (!idle) begin
					o.woken_mask = retire_thread(r);
					o.delivered_code = w.exit_code;
				end
				pick_next();
			end
			OP_JOIN: begin
				if (idle) begin
					pick_next();
				end else if (!alc_m[w.target_thread]) begin
					o.status = 1'b1;
				end else begin
					join_m[w.target_thread][r] = 1'b1;
					pick_next();
				end
			end
			OP_CANCEL: begin
				if (!alc_m[w.target_thread]) begin
					o.status = 1'b1;
				end else begin
					o.woken_mask = retire_thread(w.target_thread);
					o.delivered_code = w.exit_code;
					if (w.target_thread == r)
						pick_next();
				end
			end
			OP_WAIT: begin
				if (!idle)
					wait_m[w.queue_id][r] = 1'b1;
				pick_next();
			end
			OP_SIGNAL: begin
				h = lowest_set(wait_m[w.queue_id]);
				if (h < NTHR) begin
					wait_m[w.queue_id][h] = 1'b0;
					rdy_m[h] = 1'b1;
					o.woken_mask = 32'd1 << h;
				end
			end
			default: ;
		endcase
		o.running_thread = run_idx[5:0];
		return o;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h, want %h", $realtime, field, got, want);
		errors++;
	endtask

	function automatic int draw_gap();
		int p;
		if (no_gaps)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit next_start, next_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cmd_word <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			gap_left = 0;
			idle_cycles = 0;
		end else begin
			if (start && !busy)
				expected_words.push_back(schedule_op(cmd_word));
			if (cfg_valid && cfg_ready)
				tick_div = cfg_data;
			next_start = start && busy;
			next_cfg = cfg_valid && !cfg_ready;
			if (expected_words.size() == 0 && !busy && !start)
				idle_cycles++;
			else
				idle_cycles = 0;
			if (!next_start && !next_cfg) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					if (pending_reqs[0].is_cfg) begin
						if (idle_cycles >= 3) begin
							next_cfg = 1;
							cfg_data <= pending_reqs[0].cfg;
							void'(pending_reqs.pop_front());
							gap_left = draw_gap();
						end
					end else begin
						next_start = 1;
						cmd_word <= pending_reqs[0].word;
						void'(pending_reqs.pop_front());
						gap_left = draw_gap();
					end
				end
			end
			start <= next_start;
			cfg_valid <= next_cfg;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$display("%0t: result word with nothing expected", $realtime);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (result.running_thread !== want.running_thread)
					report("running_thread", result.running_thread, want.running_thread);
				if (result.status !== want.status)
					report("status", result.status, want.status);
				if (result.created_thread !== want.created_thread)
					report("created_thread", result.created_thread, want.created_thread);
				if (result.woken_mask !== want.woken_mask)
					report("woken_mask", result.woken_mask, want.woken_mask);
				if (result.delivered_code !== want.delivered_code)
					report("delivered_code", result.delivered_code, want.delivered_code);
			end
		end
	end

	function automatic void add_op(logic [3:0] op, logic [4:0] tgt, logic [7:0] pr,
			logic [15:0] ms, logic [2:0] q, logic [31:0] code);
		sched_req_t a;
		a.is_cfg = 0;
		a.cfg = '0;
		a.word.operation = op;
		a.word.target_thread = tgt;
		a.word.thread_priority = pr;
		a.word.sleep_ms = ms;
		a.word.queue_id = q;
		a.word.exit_code = code;
		pending_reqs.push_back(a);
	endfunction

	function automatic void add_cfg(logic [9:0] v);
		sched_req_t a;
		a.is_cfg = 1;
		a.word = '0;
		a.cfg = v;
		pending_reqs.push_back(a);
	endfunction

	function automatic void add_random_op();
		int p;
		logic [3:0] op;
		logic [15:0] ms;
		p = $urandom_range(0, 99);
		if (p < 16) op = OP_CREATE;
		else if (p < 34) op = OP_TICK;
		else if (p < 43) op = OP_YIELD;
		else if (p < 53) op = OP_SLEEP;
		else if (p < 61) op = OP_EXIT;
		else if (p < 70) op = OP_JOIN;
		else if (p < 78) op = OP_CANCEL;
		else if (p < 87) op = OP_WAIT;
		else if (p < 98) op = OP_SIGNAL;
		else op = 4'($urandom_range(9, 15));
		ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
		add_op(op, 5'($urandom), ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom), ms,
			3'($urandom), $urandom);
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		sched_reset();

		add_op(OP_TICK, 0, 0, 0, 0, 0);
		add_op(OP_CREATE, 0, 8'd0, 0, 0, 0);
		add_op(OP_CREATE, 0, 8'hff, 0, 0, 0);
		add_op(OP_SLEEP, 0, 0, 16'd250, 0, 0);
		add_op(OP_JOIN, 5'd31, 0, 0, 0, 0);
		add_op(OP_JOIN, 5'd1, 0, 0, 0, 0);
		add_op(OP_WAIT, 0, 0, 0, 3'd7, 0);
		add_op(OP_EXIT, 0, 0, 0, 0, 32'h8000_0000);
		add_op(OP_SIGNAL, 0, 0, 0, 3'd7, 0);
		add_op(OP_SIGNAL, 0, 0, 0, 3'd0, 0);
		add_op(OP_CANCEL, 5'd20, 0, 0, 0, 32'h7fff_ffff);
		add_op(OP_YIELD, 0, 0, 0, 0, 0);
		add_op(OP_TICK, 0, 0, 0, 0, 0);
		add_op(OP_TICK, 0, 0, 0, 0, 0);
		add_op(OP_TICK, 0, 0, 0, 0, 0);
		add_op(OP_EXIT, 0, 0, 0, 0, 32'hffff_ffff);
		add_op(OP_EXIT, 0, 0, 0, 0, 32'h1);
		add_op(OP_EXIT, 0, 0, 0, 0, 32'h0);
		add_op(OP_SLEEP, 0, 0, 16'hffff, 0, 0);
		add_op(OP_WAIT, 0, 0, 0, 3'd2, 0);
		add_op(OP_CANCEL, 5'd31, 0, 0, 0, 32'h1234_5678);
		add_op(OP_UNUSED, 5'h1f, 8'hff, 16'hffff, 3'd7, 32'hffff_ffff);
		add_cfg(10'd1);
		add_op(OP_CREATE, 0, 8'd1, 0, 0, 0);
		add_op(OP_SLEEP, 0, 0, 16'hffff, 0, 0);
		add_op(OP_CREATE, 0, 8'd0, 0, 0, 0);
		add_op(OP_SLEEP, 0, 0, 16'hffff, 0, 0);
		add_cfg(10'd0);
		add_op(OP_CREATE, 0, 8'd2, 0, 0, 0);
		add_op(OP_SLEEP, 0, 0, 16'd0, 0, 0);

		for (n = 0; n < 1520; n++) begin
			if (n % 190 == 0) begin
				case ((n / 190) % 5)
					0: add_cfg(10'd1000);
					1: add_cfg(10'd1023);
					2: add_cfg(10'd1);
					3: add_cfg(10'd0);
					default: add_cfg(10'($urandom_range(1, 40)));
				endcase
			end
			add_random_op();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || start || cfg_valid || expected_words.size() > 0) begin
			@(posedge clk);
			if ($urandom_range(0, 299) == 0)
				no_gaps = !no_gaps;
		end
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
